// ===== design/aoc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_pkg: shared types and helpers for the source-over pixel compositor
// Pixel payload structs, the full-alpha constant, divider stage enables and
// exact divide-by-255 helpers built from shifts and adds.
// ----------------------------------------------------------------------------
package aoc_pkg;

  localparam logic [7:0] FullAlpha = 8'd255;

  // Input transfer payload: base pixel, overlay pixel and coverage flag
  typedef struct packed {
    logic [7:0] base_alpha;
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [7:0] over_alpha;
    logic [7:0] over_red;
    logic [7:0] over_green;
    logic [7:0] over_blue;
    logic       overlay_covers;
  } in_pixel_t;

  // Output transfer payload: composited pixel
  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_pixel_t;

  // Load enables of the three divider stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } div_en_t;

  // Exact floor(x / 255) for a 16-bit x whose quotient fits in 8 bits
  function automatic logic [7:0] div255_16(input logic [15:0] x);
    logic [16:0] sum;
    sum = 17'(x) + 17'(x[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

  // Exact floor(x / 255) for a 24-bit x whose quotient fits in 16 bits:
  // x * 0x01010102 >> 32, the reciprocal rounded up
  function automatic logic [15:0] div255_24(input logic [23:0] x);
    logic [49:0] prod;
    prod = {2'b0, x, 24'b0} + {10'b0, x, 16'b0} + {18'b0, x, 8'b0}
         + {25'b0, x, 1'b0};
    return prod[47:32];
  endfunction

endpackage

// ===== design/alpha_over_composite_pixel_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_over_composite_pixel_core: source-over pixel compositor
// Blends a non-premultiplied overlay ARGB pixel over a base pixel with
// truncating integer math; uncovered or transparent overlays pass the base,
// opaque overlays replace it.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   aoc_pkg::in_pixel_t
//   out      output     out_valid_o / out_ready_i aoc_pkg::out_pixel_t
//
// One pixel per clock while out_ready_i is high; six register stages (products,
// alpha and scaling, numerator, three divider stages).
// The per-channel divide by the output alpha sets the stage count.
// Reset clears only the stage valid bits.
// A stall holds each full stage; empty stages keep filling behind it.
// ----------------------------------------------------------------------------
module alpha_over_composite_pixel_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aoc_pkg::in_pixel_t  in_pixel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aoc_pkg::out_pixel_t out_pixel_o
);

  localparam int unsigned NumStages = 6;
  localparam int unsigned NumChan = 3;

  logic [NumStages-1:0] vld_d, vld_q;
  logic [NumStages-1:0] adv;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (adv[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStages-1];

  // Stage 1: bypass select and the 8x8 products
  logic [7:0]  ch_base [NumChan];
  logic [7:0]  ch_over [NumChan];
  logic [7:0]  inv_d;
  logic        pass_d;
  logic        opaque_d;

  logic [7:0]          s1_ao_q;
  logic [7:0]          s1_inv_q;
  logic [15:0]         s1_abx_q;
  logic [15:0]         s1_cbab_q [NumChan];
  logic [15:0]         s1_coao_q [NumChan];
  aoc_pkg::out_pixel_t s1_byp_q;
  logic                s1_blend_q;

  assign ch_base[0] = in_pixel_i.base_red;
  assign ch_base[1] = in_pixel_i.base_green;
  assign ch_base[2] = in_pixel_i.base_blue;
  assign ch_over[0] = in_pixel_i.over_red;
  assign ch_over[1] = in_pixel_i.over_green;
  assign ch_over[2] = in_pixel_i.over_blue;

  assign inv_d    = aoc_pkg::FullAlpha - in_pixel_i.over_alpha;
  assign pass_d   = !in_pixel_i.overlay_covers || (in_pixel_i.over_alpha == 8'd0);
  assign opaque_d = in_pixel_i.over_alpha == aoc_pkg::FullAlpha;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_ao_q    <= in_pixel_i.over_alpha;
      s1_inv_q   <= inv_d;
      s1_abx_q   <= 16'(in_pixel_i.base_alpha) * 16'(inv_d);
      s1_blend_q <= !pass_d && !opaque_d;
      if (pass_d) begin
        s1_byp_q <= {in_pixel_i.base_alpha, in_pixel_i.base_red,
                     in_pixel_i.base_green, in_pixel_i.base_blue};
      end else begin
        s1_byp_q <= {in_pixel_i.over_alpha, in_pixel_i.over_red,
                     in_pixel_i.over_green, in_pixel_i.over_blue};
      end
      for (int c = 0; c < NumChan; c++) begin
        s1_cbab_q[c] <= 16'(ch_base[c]) * 16'(in_pixel_i.base_alpha);
        s1_coao_q[c] <= 16'(ch_over[c]) * 16'(in_pixel_i.over_alpha);
      end
    end
  end

  // Stage 2: output alpha and base term scaled by the overlay's complement
  logic [7:0]          s2_oa_q;
  logic [23:0]         s2_t_q    [NumChan];
  logic [15:0]         s2_coao_q [NumChan];
  aoc_pkg::out_pixel_t s2_byp_q;
  logic                s2_blend_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_oa_q    <= s1_ao_q + aoc_pkg::div255_16(s1_abx_q);
      s2_byp_q   <= s1_byp_q;
      s2_blend_q <= s1_blend_q;
      for (int c = 0; c < NumChan; c++) begin
        s2_t_q[c]    <= 24'(s1_cbab_q[c]) * 24'(s1_inv_q);
        s2_coao_q[c] <= s1_coao_q[c];
      end
    end
  end

  // Stage 3: blend numerator per channel
  logic [7:0]          s3_oa_q;
  logic [16:0]         s3_num_q [NumChan];
  aoc_pkg::out_pixel_t s3_byp_q;
  logic                s3_blend_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_oa_q    <= s2_oa_q;
      s3_byp_q   <= s2_byp_q;
      s3_blend_q <= s2_blend_q;
      for (int c = 0; c < NumChan; c++) begin
        s3_num_q[c] <= 17'(s2_coao_q[c]) + 17'(aoc_pkg::div255_24(s2_t_q[c]));
      end
    end
  end

  // Stages 4 to 6: divide each numerator by the output alpha
  aoc_pkg::div_en_t div_en;
  logic [7:0]       quo [NumChan];

  assign div_en = '{s1: adv[3], s2: adv[4], s3: adv[5]};

  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    aoc_div u_div (
      .clk_i (clk_i),
      .en_i  (div_en),
      .num_i (s3_num_q[c]),
      .den_i (s3_oa_q),
      .quo_o (quo[c])
    );
  end

  // Carry alpha and bypass pixel alongside the divider stages
  logic [7:0]          s4_oa_q, s5_oa_q, s6_oa_q;
  aoc_pkg::out_pixel_t s4_byp_q, s5_byp_q, s6_byp_q;
  logic                s4_blend_q, s5_blend_q, s6_blend_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_oa_q    <= s3_oa_q;
      s4_byp_q   <= s3_byp_q;
      s4_blend_q <= s3_blend_q;
    end
    if (adv[4]) begin
      s5_oa_q    <= s4_oa_q;
      s5_byp_q   <= s4_byp_q;
      s5_blend_q <= s4_blend_q;
    end
    if (adv[5]) begin
      s6_oa_q    <= s5_oa_q;
      s6_byp_q   <= s5_byp_q;
      s6_blend_q <= s5_blend_q;
    end
  end

  // Select blended or bypass pixel
  always_comb begin
    if (s6_blend_q) begin
      out_pixel_o = {s6_oa_q, quo[0], quo[1], quo[2]};
    end else begin
      out_pixel_o = s6_byp_q;
    end
  end

endmodule

// ===== design/aoc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aoc_div: three-stage restoring divider with saturation
// Divides a 17-bit numerator by an 8-bit nonzero alpha and clamps the
// quotient at 255. Quotient bits resolve three per stage at most.
// ----------------------------------------------------------------------------
module aoc_div (
  input  logic             clk_i,
  input  aoc_pkg::div_en_t en_i,
  input  logic [16:0]      num_i,
  input  logic [7:0]       den_i,
  output logic [7:0]       quo_o
);

  logic [16:0] rem_a_d, rem_a_q;
  logic [1:0]  quo_a_d, quo_a_q;
  logic        sat_a_d, sat_a_q;
  logic [7:0]  den_a_q;
  logic [16:0] rem_b_d, rem_b_q;
  logic [4:0]  quo_b_d, quo_b_q;
  logic        sat_b_q;
  logic [7:0]  den_b_q;
  logic [7:0]  quo_d, quo_q;

  // Stage one: overflow check, quotient bits 7 and 6
  always_comb begin
    logic [16:0] r;
    logic [16:0] dv;
    sat_a_d = num_i >= {1'b0, den_i, 8'b0};
    r = num_i;
    for (int i = 0; i < 2; i++) begin
      dv = {9'd0, den_i} << (7 - i);
      quo_a_d[1 - i] = (r >= dv);
      if (r >= dv) begin
        r = r - dv;
      end
    end
    rem_a_d = r;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      rem_a_q <= rem_a_d;
      quo_a_q <= quo_a_d;
      sat_a_q <= sat_a_d;
      den_a_q <= den_i;
    end
  end

  // Stage two: quotient bits 5 to 3
  always_comb begin
    logic [16:0] r;
    logic [16:0] dv;
    logic [2:0]  qb;
    r = rem_a_q;
    for (int i = 0; i < 3; i++) begin
      dv = {9'd0, den_a_q} << (5 - i);
      qb[2 - i] = (r >= dv);
      if (r >= dv) begin
        r = r - dv;
      end
    end
    rem_b_d = r;
    quo_b_d = {quo_a_q, qb};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      rem_b_q <= rem_b_d;
      quo_b_q <= quo_b_d;
      sat_b_q <= sat_a_q;
      den_b_q <= den_a_q;
    end
  end

  // Stage three: quotient bits 2 to 0, then clamp
  always_comb begin
    logic [16:0] r;
    logic [16:0] dv;
    logic [2:0]  qb;
    r = rem_b_q;
    for (int i = 0; i < 3; i++) begin
      dv = {9'd0, den_b_q} << (2 - i);
      qb[2 - i] = (r >= dv);
      if (r >= dv) begin
        r = r - dv;
      end
    end
    quo_d = sat_b_q ? aoc_pkg::FullAlpha : {quo_b_q, qb};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== bench/alpha_over_composite_pixel_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_over_composite_pixel_core_tb: self-checking bench for the compositor
// Streams base/overlay pixel pairs through the valid/ready input, predicts
// each source-over result in the bench and checks every output transfer in
// order. A directed set covers the edge cases; a random set follows, with
// random idling on both sides, a quiet stretch, a long output stall and a
// drain pause.
// ----------------------------------------------------------------------------
module alpha_over_composite_pixel_core_tb;

  localparam int unsigned RandomPixels  = 1700;
  localparam int unsigned IdlePercent   = 34;
  localparam int unsigned HoldoffCycles = 80;
  localparam int unsigned HoldoffAt     = 500;
  localparam int unsigned QuietFrom     = 900;
  localparam int unsigned QuietTo       = 1200;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned DrainCycles   = 20;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  aoc_pkg::in_pixel_t  in_pixel = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  aoc_pkg::out_pixel_t out_pixel;

  aoc_pkg::in_pixel_t  pending_q[$];
  aoc_pkg::out_pixel_t blended_q[$];
  int unsigned pixels_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_done = 1'b0;
  logic        quiet;

  alpha_over_composite_pixel_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_pixel_i (in_pixel),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_pixel_o(out_pixel)
  );

  always #5 clk_i = ~clk_i;

  // No idling on either side while this window of input transfers passes
  assign quiet = (pixels_sent >= QuietFrom) && (pixels_sent < QuietTo);

  // One blended channel: overlay share plus truncated base share, clamped
  function automatic logic [7:0] mix_channel(input int unsigned c_over,
                                             input int unsigned a_over,
                                             input int unsigned c_base,
                                             input int unsigned a_base,
                                             input int unsigned a_out);
    int unsigned num;
    int unsigned val;
    num = c_over * a_over + ((c_base * a_base) * (255 - a_over)) / 255;
    val = num / a_out;
    return (val > 255) ? 8'd255 : val[7:0];
  endfunction

  // Source-over composite of one pixel pair
  function automatic aoc_pkg::out_pixel_t blend_pixel(input aoc_pkg::in_pixel_t px);
    int unsigned ab;
    int unsigned ao;
    int unsigned a_out;
    aoc_pkg::out_pixel_t res;
    ab = 32'(px.base_alpha);
    ao = 32'(px.over_alpha);
    if (!px.overlay_covers || px.over_alpha == 8'd0) begin
      res = '{px.base_alpha, px.base_red, px.base_green, px.base_blue};
    end else if (px.over_alpha == aoc_pkg::FullAlpha) begin
      res = '{px.over_alpha, px.over_red, px.over_green, px.over_blue};
    end else begin
      a_out = ao + (ab * (255 - ao)) / 255;
      res.out_alpha = a_out[7:0];
      res.out_red   = mix_channel(32'(px.over_red), ao, 32'(px.base_red), ab, a_out);
      res.out_green = mix_channel(32'(px.over_green), ao, 32'(px.base_green), ab, a_out);
      res.out_blue  = mix_channel(32'(px.over_blue), ao, 32'(px.base_blue), ab, a_out);
    end
    return res;
  endfunction

  function automatic aoc_pkg::in_pixel_t make_px(input logic [7:0] ab, input logic [7:0] rb,
                                                 input logic [7:0] gb, input logic [7:0] bb,
                                                 input logic [7:0] ao, input logic [7:0] ro,
                                                 input logic [7:0] go, input logic [7:0] bo,
                                                 input logic cov);
    return '{ab, rb, gb, bb, ao, ro, go, bo, cov};
  endfunction

  // Alpha with extra weight on transparent, opaque and near-edge values
  function automatic logic [7:0] pick_alpha();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return 8'd0;
    if (r < 24) return 8'd255;
    if (r < 30) return 8'($urandom_range(3, 1));
    if (r < 36) return 8'($urandom_range(254, 252));
    return 8'($urandom_range(255));
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want)
      report_error($sformatf("pixel %0d %s: expected %0d, got %0d",
                             pixels_checked, name, want, got));
  endtask

  // Hold until every queued pixel is taken and every result is back
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || blended_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Input driver: present queued pixels, idling at random between transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_pixel <= '0;
    end else begin
      if (in_valid && in_ready) begin
        blended_q.push_back(blend_pixel(in_pixel));
        pixels_sent <= pixels_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && (quiet || $urandom_range(99) >= IdlePercent)) begin
          in_valid <= 1'b1;
          in_pixel <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output ready: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready    <= 1'b0;
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (holdoff_left != 0) begin
      out_ready    <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && pixels_checked >= HoldoffAt) begin
      out_ready    <= 1'b0;
      holdoff_left <= HoldoffCycles;
      holdoff_done <= 1'b1;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Output monitor: compare each transfer with the oldest predicted pixel
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (blended_q.size() == 0) begin
        report_error($sformatf("unexpected output pixel %h", out_pixel));
      end else begin
        aoc_pkg::out_pixel_t want;
        want = blended_q.pop_front();
        check_field("alpha", want.out_alpha, out_pixel.out_alpha);
        check_field("red", want.out_red, out_pixel.out_red);
        check_field("green", want.out_green, out_pixel.out_green);
        check_field("blue", want.out_blue, out_pixel.out_blue);
      end
      pixels_checked <= pixels_checked + 1;
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    aoc_pkg::in_pixel_t px;
    // Directed set: extremes, pass-through, replace, blend and saturation
    pending_q.push_back(make_px(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
    pending_q.push_back(make_px(8'd255, 8'd255, 8'd255, 8'd255,
                                8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    pending_q.push_back(make_px(8'd200, 8'd10, 8'd20, 8'd30,
                                8'd128, 8'd250, 8'd240, 8'd230, 1'b0));
    pending_q.push_back(make_px(8'd255, 8'd255, 8'd255, 8'd255,
                                8'd255, 8'd0, 8'd0, 8'd0, 1'b0));
    pending_q.push_back(make_px(8'd90, 8'd1, 8'd2, 8'd3, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1));
    pending_q.push_back(make_px(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    pending_q.push_back(make_px(8'd77, 8'd200, 8'd100, 8'd50,
                                8'd255, 8'd12, 8'd34, 8'd56, 1'b1));
    pending_q.push_back(make_px(8'd0, 8'd255, 8'd255, 8'd255,
                                8'd255, 8'd0, 8'd0, 8'd0, 1'b1));
    pending_q.push_back(make_px(8'd255, 8'd255, 8'd0, 8'd128,
                                8'd1, 8'd0, 8'd255, 8'd128, 1'b1));
    pending_q.push_back(make_px(8'd255, 8'd0, 8'd255, 8'd128,
                                8'd254, 8'd255, 8'd0, 8'd127, 1'b1));
    pending_q.push_back(make_px(8'd0, 8'd255, 8'd255, 8'd255,
                                8'd128, 8'd255, 8'd0, 8'd170, 1'b1));
    pending_q.push_back(make_px(8'd128, 8'd85, 8'd170, 8'd255,
                                8'd128, 8'd170, 8'd85, 8'd0, 1'b1));
    // Tiny alphas: truncated output alpha drives channels past full scale
    pending_q.push_back(make_px(8'd1, 8'd255, 8'd255, 8'd255,
                                8'd1, 8'd255, 8'd255, 8'd255, 1'b1));
    pending_q.push_back(make_px(8'd3, 8'd255, 8'd200, 8'd255,
                                8'd2, 8'd255, 8'd255, 8'd100, 1'b1));
    pending_q.push_back(make_px(8'd254, 8'd255, 8'd255, 8'd255,
                                8'd1, 8'd255, 8'd255, 8'd255, 1'b1));
    pending_q.push_back(make_px(8'd255, 8'd1, 8'd1, 8'd1, 8'd254, 8'd254, 8'd254, 8'd254, 1'b1));
    pending_q.push_back(make_px(8'd170, 8'd85, 8'd85, 8'd85,
                                8'd85, 8'd170, 8'd170, 8'd170, 1'b1));
    pending_q.push_back(make_px(8'd85, 8'd170, 8'd85, 8'd170,
                                8'd170, 8'd85, 8'd170, 8'd85, 1'b1));

    // Reset, then let the directed set drain before the random set starts
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // Random set: alphas weighted toward the interesting corners
    for (int unsigned i = 0; i < RandomPixels; i++) begin
      px.base_alpha     = pick_alpha();
      px.base_red       = 8'($urandom_range(255));
      px.base_green     = 8'($urandom_range(255));
      px.base_blue      = 8'($urandom_range(255));
      px.over_alpha     = pick_alpha();
      px.over_red       = 8'($urandom_range(255));
      px.over_green     = 8'($urandom_range(255));
      px.over_blue      = 8'($urandom_range(255));
      px.overlay_covers = ($urandom_range(99) < 85);
      pending_q.push_back(px);
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
